>>> design/v3au_pkg.sv
// Shared types and constants of the three-component vector arithmetic unit.
package v3au_pkg;

  localparam int unsigned XW        = 32;        // width of a vector component
  localparam int unsigned OPW       = XW + 1;    // multiplier operand, holds 1 - t
  localparam int unsigned PW        = 2 * OPW;   // full product width
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned NUM_COMP  = 3;
  localparam int unsigned NUM_LANES = 2 * NUM_COMP;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 3'd0,
    FUNC_SUB   = 3'd1,
    FUNC_MUL   = 3'd2,
    FUNC_DOT   = 3'd3,
    FUNC_CROSS = 3'd4,
    FUNC_LERP  = 3'd5
  } func_e;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

>>> design/v3au_opsel.sv
// Stage 1: operand routing to the six multiplier lanes and the exact add/subtract.
module v3au_opsel #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  v3au_pkg::pipe_en_t                     en_i,
  input  logic [v3au_pkg::FUNC_W-1:0]            func_i,
  input  logic signed [v3au_pkg::XW-1:0]         a_i [v3au_pkg::NUM_COMP],
  input  logic signed [v3au_pkg::XW-1:0]         b_i [v3au_pkg::NUM_COMP],
  input  logic signed [v3au_pkg::XW-1:0]         t_i,
  output logic [v3au_pkg::FUNC_W-1:0]            func_o,
  output logic signed [v3au_pkg::OPW-1:0]        opx_o [v3au_pkg::NUM_LANES],
  output logic signed [v3au_pkg::OPW-1:0]        opy_o [v3au_pkg::NUM_LANES],
  output logic signed [v3au_pkg::OPW-1:0]        lin_o [v3au_pkg::NUM_COMP]
);

  localparam int unsigned OPW = v3au_pkg::OPW;
  localparam int unsigned NC  = v3au_pkg::NUM_COMP;
  localparam int unsigned NL  = v3au_pkg::NUM_LANES;
  localparam logic signed [OPW-1:0] ONE = OPW'(1) << FRAC_BITS;

  logic signed [OPW-1:0] a_ext [NC];
  logic signed [OPW-1:0] b_ext [NC];
  logic signed [OPW-1:0] t_ext;
  logic signed [OPW-1:0] omt;
  logic signed [OPW-1:0] opx_d [NL];
  logic signed [OPW-1:0] opy_d [NL];
  logic signed [OPW-1:0] lin_d [NC];
  logic [v3au_pkg::FUNC_W-1:0] func_q;
  logic signed [OPW-1:0] opx_q [NL];
  logic signed [OPW-1:0] opy_q [NL];
  logic signed [OPW-1:0] lin_q [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      a_ext[i] = {a_i[i][v3au_pkg::XW-1], a_i[i]};
      b_ext[i] = {b_i[i][v3au_pkg::XW-1], b_i[i]};
      lin_d[i] = (func_i == v3au_pkg::FUNC_SUB) ? a_ext[i] - b_ext[i] : a_ext[i] + b_ext[i];
    end
    t_ext = {t_i[v3au_pkg::XW-1], t_i};
    omt   = ONE - t_ext;
    for (int l = 0; l < NL; l++) begin
      opx_d[l] = '0;
      opy_d[l] = '0;
    end
    case (func_i)
      v3au_pkg::FUNC_MUL, v3au_pkg::FUNC_DOT: begin
        for (int i = 0; i < NC; i++) begin
          opx_d[i] = a_ext[i];
          opy_d[i] = b_ext[i];
        end
      end
      v3au_pkg::FUNC_CROSS: begin
        // lane i minus lane i+3 gives component i
        opx_d[0] = a_ext[1]; opy_d[0] = b_ext[2];
        opx_d[3] = a_ext[2]; opy_d[3] = b_ext[1];
        opx_d[1] = a_ext[2]; opy_d[1] = b_ext[0];
        opx_d[4] = a_ext[0]; opy_d[4] = b_ext[2];
        opx_d[2] = a_ext[0]; opy_d[2] = b_ext[1];
        opx_d[5] = a_ext[1]; opy_d[5] = b_ext[0];
      end
      v3au_pkg::FUNC_LERP: begin
        for (int i = 0; i < NC; i++) begin
          opx_d[i]      = a_ext[i];
          opy_d[i]      = omt;
          opx_d[i + NC] = b_ext[i];
          opy_d[i + NC] = t_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      func_q <= func_i;
      opx_q  <= opx_d;
      opy_q  <= opy_d;
      lin_q  <= lin_d;
    end
  end

  assign func_o = func_q;
  assign opx_o  = opx_q;
  assign opy_o  = opy_q;
  assign lin_o  = lin_q;

endmodule

>>> design/v3au_lane.sv
// Stages 2 and 3 of one multiplier lane: full product, then rounding toward zero.
module v3au_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  v3au_pkg::pipe_en_t                            en_i,
  input  logic signed [v3au_pkg::OPW-1:0]               x_i,
  input  logic signed [v3au_pkg::OPW-1:0]               y_i,
  output logic signed [v3au_pkg::PW-FRAC_BITS-1:0]      rnd_o
);

  localparam int unsigned PW = v3au_pkg::PW;
  localparam int unsigned RW = PW - FRAC_BITS;

  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_q;
  logic        [PW-1:0] bias;
  logic        [PW-1:0] biased;
  logic signed [RW-1:0] rnd_q;

  assign prod_d = x_i * y_i;

  // Negative products get 2^F - 1 added so the arithmetic shift truncates toward zero.
  assign bias   = {{RW{1'b0}}, {FRAC_BITS{prod_q[PW-1]}}};
  assign biased = prod_q + bias;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
    end
    if (en_i.s3) begin
      rnd_q <= biased[PW-1:FRAC_BITS];
    end
  end

  assign rnd_o = rnd_q;

endmodule

>>> design/v3au_combine.sv
// Stages 4 and 5: combine rounded products or add/subtract sums into results, then saturate.
module v3au_combine #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  v3au_pkg::pipe_en_t                            en_i,
  input  logic [v3au_pkg::FUNC_W-1:0]                   func_i,
  input  logic signed [v3au_pkg::OPW-1:0]               lin_i [v3au_pkg::NUM_COMP],
  input  logic signed [v3au_pkg::PW-FRAC_BITS-1:0]      rnd_i [v3au_pkg::NUM_LANES],
  output logic signed [v3au_pkg::XW-1:0]                r_o   [v3au_pkg::NUM_COMP],
  output logic signed [v3au_pkg::XW-1:0]                scalar_o,
  output logic                                          ovf_o
);

  localparam int unsigned XW  = v3au_pkg::XW;
  localparam int unsigned OPW = v3au_pkg::OPW;
  localparam int unsigned NC  = v3au_pkg::NUM_COMP;
  localparam int unsigned NL  = v3au_pkg::NUM_LANES;
  localparam int unsigned RW  = v3au_pkg::PW - FRAC_BITS;
  localparam int unsigned SW  = RW + 2;

  typedef struct packed {
    logic          ovf;
    logic [XW-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [SW-1:0] v);
    sat_t                res;
    logic [SW-XW:0]      upper;
    upper = v[SW-1:XW-1];
    if ((&upper) || !(|upper)) begin
      res.ovf = 1'b0;
      res.val = v[XW-1:0];
    end else begin
      res.ovf = 1'b1;
      res.val = v[SW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [SW-1:0] p_ext [NL];
  logic signed [SW-1:0] vec_d [NC];
  logic signed [SW-1:0] dot_d;
  logic signed [SW-1:0] vec_q [NC];
  logic signed [SW-1:0] dot_q;
  sat_t                 vsat  [NC];
  sat_t                 dsat;
  logic signed [XW-1:0] r_q   [NC];
  logic signed [XW-1:0] scalar_q;
  logic                 ovf_q;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      p_ext[l] = {{(SW-RW){rnd_i[l][RW-1]}}, rnd_i[l]};
    end
    for (int i = 0; i < NC; i++) begin
      case (func_i)
        v3au_pkg::FUNC_ADD, v3au_pkg::FUNC_SUB:
          vec_d[i] = {{(SW-OPW){lin_i[i][OPW-1]}}, lin_i[i]};
        v3au_pkg::FUNC_MUL:   vec_d[i] = p_ext[i];
        v3au_pkg::FUNC_CROSS: vec_d[i] = p_ext[i] - p_ext[i + NC];
        v3au_pkg::FUNC_LERP:  vec_d[i] = p_ext[i] + p_ext[i + NC];
        default:              vec_d[i] = '0;
      endcase
    end
    dot_d = (func_i == v3au_pkg::FUNC_DOT) ? p_ext[0] + p_ext[1] + p_ext[2] : '0;
  end

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      vsat[i] = sat32(vec_q[i]);
    end
    dsat = sat32(dot_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      vec_q <= vec_d;
      dot_q <= dot_d;
    end
    if (en_i.s5) begin
      for (int i = 0; i < NC; i++) begin
        r_q[i] <= vsat[i].val;
      end
      scalar_q <= dsat.val;
      ovf_q    <= vsat[0].ovf | vsat[1].ovf | vsat[2].ovf | dsat.ovf;
    end
  end

  assign r_o      = r_q;
  assign scalar_o = scalar_q;
  assign ovf_o    = ovf_q;

endmodule

>>> design/vec3_arithmetic_unit.sv
// Top level of the pipelined three-component Q16.16 vector arithmetic unit.
//
//   channel  direction  handshake                   payload
//   in       sink       in_valid_i / in_ready_o     func_i, a_*_i, b_*_i, t_frac_i
//   out      source     out_valid_o / out_ready_i   r_x_o, r_y_o, r_z_o, r_scalar_o, overflow_o
//
// Five register stages: operand routing, multiply, round, combine, saturate.
// out_valid_o rises when an accepted item has reached the saturate stage; throughput
// is one item per cycle while out_ready_i does not stall, set by the six
// 33x33 multiplier lanes that every item passes once.
// Reset clears only the stage valid bits; payload registers carry no reset.
// A stage loads whenever it is empty or the stage after it moves, so a stall on
// out_ready_i backs up stage by stage and bubbles are squeezed out.
module vec3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] a_z_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [31:0] b_z_i,
  input  logic [31:0] t_frac_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] r_x_o,
  output logic [31:0] r_y_o,
  output logic [31:0] r_z_o,
  output logic [31:0] r_scalar_o,
  output logic        overflow_o
);

  localparam int unsigned XW  = v3au_pkg::XW;
  localparam int unsigned OPW = v3au_pkg::OPW;
  localparam int unsigned NC  = v3au_pkg::NUM_COMP;
  localparam int unsigned NL  = v3au_pkg::NUM_LANES;
  localparam int unsigned RW  = v3au_pkg::PW - FRAC_BITS;

  // Stage valid bits and the ready chain running back from the output.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  v3au_pkg::pipe_en_t en;

  assign rdy5 = !v5_q || out_ready_i;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;
  assign en.s5 = rdy5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v5_q;

  // Stage 1: route operands to the lanes, form a+b or a-b exactly.
  logic signed [XW-1:0]  a_vec [NC];
  logic signed [XW-1:0]  b_vec [NC];
  logic [v3au_pkg::FUNC_W-1:0] func_s1;
  logic signed [OPW-1:0] opx [NL];
  logic signed [OPW-1:0] opy [NL];
  logic signed [OPW-1:0] lin_s1 [NC];

  assign a_vec[0] = a_x_i;
  assign a_vec[1] = a_y_i;
  assign a_vec[2] = a_z_i;
  assign b_vec[0] = b_x_i;
  assign b_vec[1] = b_y_i;
  assign b_vec[2] = b_z_i;

  v3au_opsel #(
    .FRAC_BITS(FRAC_BITS)
  ) u_opsel (
    .clk_i (clk_i),
    .en_i  (en),
    .func_i(func_i),
    .a_i   (a_vec),
    .b_i   (b_vec),
    .t_i   (t_frac_i),
    .func_o(func_s1),
    .opx_o (opx),
    .opy_o (opy),
    .lin_o (lin_s1)
  );

  // Stages 2 and 3: six multiply-and-round lanes.
  logic signed [RW-1:0] rnd [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    v3au_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i(clk_i),
      .en_i (en),
      .x_i  (opx[l]),
      .y_i  (opy[l]),
      .rnd_o(rnd[l])
    );
  end

  // Carry the operation code and the add/subtract result alongside the lanes.
  logic [v3au_pkg::FUNC_W-1:0] func_s2_q, func_s3_q;
  logic signed [OPW-1:0]       lin_s2_q [NC];
  logic signed [OPW-1:0]       lin_s3_q [NC];

  always_ff @(posedge clk_i) begin
    if (en.s2) begin
      func_s2_q <= func_s1;
      lin_s2_q  <= lin_s1;
    end
    if (en.s3) begin
      func_s3_q <= func_s2_q;
      lin_s3_q  <= lin_s2_q;
    end
  end

  // Stages 4 and 5: combine per operation, then saturate and flag overflow.
  logic signed [XW-1:0] r_vec [NC];

  v3au_combine #(
    .FRAC_BITS(FRAC_BITS)
  ) u_combine (
    .clk_i   (clk_i),
    .en_i    (en),
    .func_i  (func_s3_q),
    .lin_i   (lin_s3_q),
    .rnd_i   (rnd),
    .r_o     (r_vec),
    .scalar_o(r_scalar_o),
    .ovf_o   (overflow_o)
  );

  assign r_x_o = r_vec[0];
  assign r_y_o = r_vec[1];
  assign r_z_o = r_vec[2];

endmodule

>>> bench/tb_vec3_arithmetic_unit.sv
// Self-checking testbench for the pipelined three-component vector arithmetic unit.
`timescale 1ns / 100ps

module tb_vec3_arithmetic_unit;

  localparam int unsigned FRAC_BITS = 16;
  // Codes the block leaves unused: every result field reads zero.
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_HALF = 32'h0000_8000;
  localparam int unsigned RANDOM_ITEMS = 1300;

  // One input item and one result item, as the ports carry them.
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] ax, ay, az;
    logic [31:0] bx, by, bz;
    logic [31:0] t;
  } vec_op_t;

  typedef struct packed {
    logic [31:0] x, y, z, s;
    logic        ovf;
  } vec_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic [31:0] t_frac = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] r_x, r_y, r_z, r_scalar;
  logic        overflow;

  // Expected results, oldest first, pushed when the block accepts an item.
  vec_res_t exp_results[$];
  vec_res_t got_res;

  int errors = 0;
  int results_seen = 0;
  int sat_results = 0;
  int stall_cycles = 0;
  int op_seen[8];

  // Sender pacing: bursts of random length separated by random gaps.
  bit sender_paced = 1'b1;
  int burst_left = 0;

  // Receiver: either always ready or cycling through stall patterns.
  bit rx_always = 1'b0;
  int rx_cnt = 0;
  int rx_mode = 0;
  logic [31:0] rx_pat = '1;

  vec3_arithmetic_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .func_i     (func),
    .a_x_i      (a_x),
    .a_y_i      (a_y),
    .a_z_i      (a_z),
    .b_x_i      (b_x),
    .b_y_i      (b_y),
    .b_z_i      (b_z),
    .t_frac_i   (t_frac),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .r_x_o      (r_x),
    .r_y_o      (r_y),
    .r_z_o      (r_z),
    .r_scalar_o (r_scalar),
    .overflow_o (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact double-width product, truncated toward zero by FRAC_BITS.
  function automatic longint mul_rtz(input longint x, input longint y);
    longint p;
    p = x * y;
    if (p < 0) return -((-p) >>> FRAC_BITS);
    return p >>> FRAC_BITS;
  endfunction

  function automatic bit out_of_q16(input longint v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic vec_res_t vec3_predict(input vec_op_t op);
    longint   a[3], b[3], r[3];
    longint   t, w, dot;
    bit       is_vec, ovf;
    int       i;
    vec_res_t res;
    a[0] = longint'($signed(op.ax));
    a[1] = longint'($signed(op.ay));
    a[2] = longint'($signed(op.az));
    b[0] = longint'($signed(op.bx));
    b[1] = longint'($signed(op.by));
    b[2] = longint'($signed(op.bz));
    t = longint'($signed(op.t));
    for (i = 0; i < 3; i++) r[i] = 0;
    dot = 0;
    is_vec = 1'b1;
    ovf = 1'b0;
    case (op.func)
      v3au_pkg::FUNC_ADD: for (i = 0; i < 3; i++) r[i] = a[i] + b[i];
      v3au_pkg::FUNC_SUB: for (i = 0; i < 3; i++) r[i] = a[i] - b[i];
      v3au_pkg::FUNC_MUL: for (i = 0; i < 3; i++) r[i] = mul_rtz(a[i], b[i]);
      v3au_pkg::FUNC_DOT: begin
        is_vec = 1'b0;
        dot = mul_rtz(a[0], b[0]) + mul_rtz(a[1], b[1]) + mul_rtz(a[2], b[2]);
      end
      v3au_pkg::FUNC_CROSS: begin
        r[0] = mul_rtz(a[1], b[2]) - mul_rtz(a[2], b[1]);
        r[1] = mul_rtz(a[2], b[0]) - mul_rtz(a[0], b[2]);
        r[2] = mul_rtz(a[0], b[1]) - mul_rtz(a[1], b[0]);
      end
      v3au_pkg::FUNC_LERP: begin
        // 1 - t stays exact at 33 bits; each side truncates on its own.
        w = (longint'(1) << FRAC_BITS) - t;
        for (i = 0; i < 3; i++) r[i] = mul_rtz(a[i], w) + mul_rtz(b[i], t);
      end
      default: is_vec = 1'b0;
    endcase
    res = '0;
    if (is_vec) begin
      res.x = clamp_q16(r[0]);
      res.y = clamp_q16(r[1]);
      res.z = clamp_q16(r[2]);
      ovf = out_of_q16(r[0]) || out_of_q16(r[1]) || out_of_q16(r[2]);
    end
    if (op.func == v3au_pkg::FUNC_DOT) begin
      res.s = clamp_q16(dot);
      ovf = out_of_q16(dot);
    end
    res.ovf = ovf;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Take a gap after the burst runs out; the gap always spans a clock edge,
  // so valid never drops and rises within one step.
  task automatic pace_sender();
    int gap;
    if (sender_paced) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Offer one item, hold it until the edge that accepts it, then log the expectation.
  task automatic send_vec(input vec_op_t op);
    in_valid <= 1'b1;
    func     <= op.func;
    a_x      <= op.ax;
    a_y      <= op.ay;
    a_z      <= op.az;
    b_x      <= op.bx;
    b_y      <= op.by;
    b_z      <= op.bz;
    t_frac   <= op.t;
    do @(posedge clk); while (!in_ready);
    exp_results.push_back(vec3_predict(op));
    op_seen[op.func]++;
    pace_sender();
  endtask

  task automatic send_fields(input logic [2:0] f,
                             input logic [31:0] ax, ay, az, bx, by, bz, t);
    vec_op_t op;
    op.func = f;
    op.ax = ax;
    op.ay = ay;
    op.az = az;
    op.bx = bx;
    op.by = by;
    op.bz = bz;
    op.t  = t;
    send_vec(op);
  endtask

  // Drop valid if the last item left it high, so nothing is offered twice.
  task automatic quiet_sender();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of full-range words, corner values and small or scaled magnitudes.
  function automatic logic [31:0] rand_q16();
    int sh;
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(0, 6))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          3: return 32'hFFFF_FFFF;
          4: return Q_ONE;
          5: return -Q_ONE;
          default: return 32'h0000_0001;
        endcase
      end
      3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: begin
        sh = $urandom_range(0, 20);
        return $signed($urandom()) >>> sh;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    if ($urandom_range(0, 4) < 3) return $urandom_range(0, Q_ONE);
    return rand_q16();
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------

  // Pick a new stall pattern each time rx_cnt wraps to zero: open, mostly ready,
  // a bit pattern, or starved.
  always @(posedge clk) begin
    if (rx_always) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_cnt == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_pat  = $urandom();
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= rx_pat[rx_cnt % 32];
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
      rx_cnt = (rx_cnt + 1) % 96;
    end
  end

  task automatic check_result(input vec_res_t got);
    vec_res_t want;
    if (exp_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result with nothing expected: x=%h y=%h z=%h s=%h ovf=%b",
                 $realtime, got.x, got.y, got.z, got.s, got.ovf);
    end else begin
      want = exp_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected x=%h y=%h z=%h s=%h ovf=%b",
                   want.x, want.y, want.z, want.s, want.ovf);
          $display("  actual   x=%h y=%h z=%h s=%h ovf=%b",
                   got.x, got.y, got.z, got.s, got.ovf);
        end
      end
    end
  endtask

  // Outputs are sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (!out_ready) begin
        stall_cycles++;
      end else begin
        got_res.x   = r_x;
        got_res.y   = r_y;
        got_res.z   = r_z;
        got_res.s   = r_scalar;
        got_res.ovf = overflow;
        results_seen++;
        if (overflow === 1'b1) sat_results++;
        check_result(got_res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_add_sub();
    send_fields(v3au_pkg::FUNC_ADD, Q_MAX, Q_MAX, 32'h0001_8000, 32'h0000_0001, Q_MAX,
                32'hFFFE_8000, Q_ONE);
    send_fields(v3au_pkg::FUNC_ADD, Q_MIN, Q_MIN, '0, 32'hFFFF_FFFF, Q_MIN, '0, '0);
    send_fields(v3au_pkg::FUNC_SUB, Q_MIN, Q_MAX, 32'h0003_0000, Q_MAX, Q_MIN,
                32'h0001_0000, $urandom());
    send_fields(v3au_pkg::FUNC_SUB, '0, 32'hFFFF_FFFF, Q_MAX, Q_MIN, '0,
                32'hFFFF_FFFF, '0);
    quiet_sender();
  endtask

  // Check truncation toward zero on negative products, product saturation and dot-product sums.
  task automatic test_mul_dot();
    send_fields(v3au_pkg::FUNC_MUL, 32'hFFFF_FFFF, 32'hFFFF_8000, Q_MIN,
                Q_HALF, 32'h0000_8001, Q_MIN, '0);
    send_fields(v3au_pkg::FUNC_MUL, 32'hFFFE_8000, Q_MAX, 32'h0000_0003,
                Q_ONE, Q_MIN, 32'hFFFF_FFFF, '0);
    // In-range products whose sum leaves the range, both signs.
    send_fields(v3au_pkg::FUNC_DOT, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                Q_ONE, Q_ONE, Q_ONE, '0);
    send_fields(v3au_pkg::FUNC_DOT, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
                -Q_ONE, -Q_ONE, -Q_ONE, '0);
    send_fields(v3au_pkg::FUNC_DOT, 32'h0002_0000, 32'hFFFF_8000, 32'h0000_0001,
                32'h0003_0000, 32'h0004_0000, 32'hFFFF_FFFF, Q_MAX);
    send_fields(v3au_pkg::FUNC_DOT, Q_MIN, '0, '0, Q_MIN, '0, '0, '0);
    quiet_sender();
  endtask

  // x cross z must give minus y; a general case and full-scale operands follow.
  task automatic test_cross();
    send_fields(v3au_pkg::FUNC_CROSS, Q_ONE, '0, '0, '0, '0, Q_ONE, '0);
    send_fields(v3au_pkg::FUNC_CROSS, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                32'h0004_0000, 32'h0005_0000, 32'h0006_0000, '0);
    send_fields(v3au_pkg::FUNC_CROSS, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0);
    quiet_sender();
  endtask

  task automatic test_lerp();
    send_fields(v3au_pkg::FUNC_LERP, 32'h0001_2345, 32'hFFF0_0000, Q_MAX,
                32'h0007_0000, 32'h0000_0001, Q_MIN, '0);
    send_fields(v3au_pkg::FUNC_LERP, 32'h0001_2345, 32'hFFF0_0000, Q_MAX,
                32'h0007_0000, 32'h0000_0001, Q_MIN, Q_ONE);
    send_fields(v3au_pkg::FUNC_LERP, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_0003,
                32'h0000_0001, 32'hFFFE_0000, 32'hFFFF_FFFD, Q_HALF);
    // Largest 1 - t weight.
    send_fields(v3au_pkg::FUNC_LERP, Q_MAX, 32'h0000_0001, '0, '0, '0, Q_MAX, Q_MIN);
    send_fields(v3au_pkg::FUNC_LERP, Q_MIN, '0, 32'h0000_8000, Q_MIN, Q_ONE, '0, Q_MAX);
    quiet_sender();
  endtask

  task automatic test_unused_codes();
    send_fields(FUNC_RSVD6, Q_MAX, Q_MIN, Q_ONE, Q_MAX, Q_MIN, Q_ONE, Q_MAX);
    send_fields(FUNC_RSVD7, 32'hFFFF_FFFF, Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MAX,
                Q_MIN, Q_MIN);
    quiet_sender();
  endtask

  // Back-to-back items into an open receiver: the pipeline runs at full rate.
  task automatic test_full_rate();
    vec_op_t op;
    sender_paced = 1'b0;
    rx_always = 1'b1;
    repeat (64) begin
      op.func = $urandom_range(v3au_pkg::FUNC_ADD, v3au_pkg::FUNC_LERP);
      op.ax = rand_q16();
      op.ay = rand_q16();
      op.az = rand_q16();
      op.bx = rand_q16();
      op.by = rand_q16();
      op.bz = rand_q16();
      op.t  = rand_weight();
      send_vec(op);
    end
    quiet_sender();
    sender_paced = 1'b1;
    rx_always = 1'b0;
  endtask

  task automatic test_random_stream();
    vec_op_t op;
    repeat (RANDOM_ITEMS) begin
      op.func = ($urandom_range(0, 19) == 0)
                  ? $urandom_range(FUNC_RSVD6, FUNC_RSVD7)
                  : $urandom_range(v3au_pkg::FUNC_ADD, v3au_pkg::FUNC_LERP);
      op.ax = rand_q16();
      op.ay = rand_q16();
      op.az = rand_q16();
      op.bx = rand_q16();
      op.by = rand_q16();
      op.bz = rand_q16();
      op.t  = (op.func == v3au_pkg::FUNC_LERP) ? rand_weight() : $urandom();
      send_vec(op);
    end
    quiet_sender();
  endtask

  // ---------------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------------

  initial begin
    int spins;
    for (int k = 0; k < 8; k++) op_seen[k] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    test_add_sub();
    test_mul_dot();
    test_cross();
    test_lerp();
    test_unused_codes();
    test_full_rate();
    test_random_stream();

    // Drain what is still in flight, then let the pipeline settle.
    spins = 0;
    while (exp_results.size() != 0 && spins < 100000) begin
      @(posedge clk);
      spins++;
    end
    repeat (20) @(posedge clk);

    if (exp_results.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", exp_results.size());
    end
    $display("Checked %0d results (add %0d, sub %0d, mul %0d, dot %0d, cross %0d, lerp %0d,",
             results_seen, op_seen[v3au_pkg::FUNC_ADD], op_seen[v3au_pkg::FUNC_SUB],
             op_seen[v3au_pkg::FUNC_MUL], op_seen[v3au_pkg::FUNC_DOT],
             op_seen[v3au_pkg::FUNC_CROSS], op_seen[v3au_pkg::FUNC_LERP]);
    $display("  unused codes %0d); %0d saturated, %0d output stall cycles, %0d errors.",
             op_seen[FUNC_RSVD6] + op_seen[FUNC_RSVD7], sat_results, stall_cycles, errors);
    if (errors == 0) begin
      $display("** vec3_arithmetic_unit: PASSED **");
    end else begin
      $display("** vec3_arithmetic_unit: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected", exp_results.size());
    $display("** vec3_arithmetic_unit: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
design/v3au_pkg.sv
design/v3au_opsel.sv
design/v3au_lane.sv
design/v3au_combine.sv
design/vec3_arithmetic_unit.sv
bench/tb_vec3_arithmetic_unit.sv
